### rtl/core/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;   // holds 0..TABLE_DEPTH
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 9;
  localparam int unsigned OUT_DATA_W  = 16;           // position padded to bytes

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

endpackage : stbs_pkg

`default_nettype wire

### rtl/core/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Table of ascending signed words with an iterative binary search engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tuser carries the operation, tdata the value.
//     clear  - empties the table, no result.
//     append - writes value as the next entry; dropped when the table is full.
//     search - looks up value; exactly one result transfer follows.
//   Output stream (m_axis): tdata[8:0] is the position (matching index, or
//   the insertion point when nothing matches), tuser[0] is the found flag.
//   Clear and append leave ready high. Each search probe is a memory read
//   (ST_READ) then a compare (ST_CMP), at most log2(depth)+1 = 9 probes,
//   and ST_DONE then loads the output register. Ready returns in the
//   cycle tvalid rises. The table memory is read once per probe.
//   Ready is low while a search runs. A finished result sits in the output
//   register; the next item is accepted while it waits, and a following
//   search holds in its final state until the receiver takes the old result.
//   Reset empties the table (count to zero) and drops any pending result;
//   entry contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_top
  import stbs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [VALUE_W-1:0]    s_axis_tdata_i,   // [31:0] value
  input  wire logic [OP_W-1:0]       s_axis_tuser_i,   // [1:0] operation
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,   // [8:0] position, [15:9] zero
  output logic                       m_axis_tuser_o    // [0] found
);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_CMP   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // table storage, one write port and one read port
  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_q;

  logic [CNT_W-1:0]   count_q;
  logic [VALUE_W-1:0] key_q;
  // search window is [low, hi1): hi1 is one past the last candidate
  logic [CNT_W-1:0]   low_q, low_d;
  logic [CNT_W-1:0]   hi1_q, hi1_d;
  logic [CNT_W-1:0]   mid_q;
  logic               found_q, found_d;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_next;

  logic               in_xfer;
  logic               out_xfer;
  logic               do_append;
  logic               out_load;
  logic               probe_lt;
  logic               probe_gt;
  op_e                op_in;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign op_in           = op_e'(s_axis_tuser_i);
  assign do_append       = in_xfer && (op_in == OP_APPEND)
                           && (count_q < CNT_W'(TABLE_DEPTH));

  // floor((low + high) / 2) with high = hi1 - 1; only used while low < hi1
  assign mid_sum  = {1'b0, low_q} + {1'b0, hi1_q} - (CNT_W+1)'(1);
  assign mid_next = mid_sum[CNT_W:1];

  assign probe_lt = $signed(rd_q) < $signed(key_q);
  assign probe_gt = $signed(rd_q) > $signed(key_q);

  // output register loads once the previous result has gone
  assign out_load = (state_q == ST_DONE) && (!m_axis_tvalid_o || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    hi1_d   = hi1_q;
    found_d = found_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (op_in == OP_SEARCH)) begin
          low_d   = '0;
          hi1_d   = count_q;
          found_d = 1'b0;
          state_d = (count_q == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        priority if (probe_lt) begin
          low_d = mid_q + CNT_W'(1);
        end else if (probe_gt) begin
          hi1_d = mid_q;
        end else begin
          found_d = 1'b1;
        end
        if (!probe_lt && !probe_gt) begin
          state_d = ST_DONE;
        end else if (low_d < hi1_d) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      count_q         <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer && (op_in == OP_CLEAR)) begin
        count_q <= '0;
      end else if (do_append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (out_load) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (out_xfer) begin
        m_axis_tvalid_o <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    hi1_q   <= hi1_d;
    found_q <= found_d;
    if (in_xfer) begin
      key_q <= s_axis_tdata_i;
    end
    if (state_q == ST_READ) begin
      mid_q <= mid_next;
    end
    if (out_load) begin
      m_axis_tdata_o <= OUT_DATA_W'(found_q ? mid_q : low_q);
      m_axis_tuser_o <= found_q;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_append) begin
      mem[count_q[ADDR_W-1:0]] <= s_axis_tdata_i;
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[mid_next[ADDR_W-1:0]];
    end
  end

endmodule : sorted_table_binary_search_top

`default_nettype wire

### rtl/core/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted-table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_checker
  import stbs_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [OP_W-1:0]       s_axis_tuser_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  m_axis_tuser_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a search transfer always takes ready low
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser_i == OP_SEARCH) |=> !s_axis_tready_o)
    else $error("ready stayed high after a search transfer");

  // clear, append and unused codes leave ready high
  a_simple_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser_i != OP_SEARCH) |=> s_axis_tready_o)
    else $error("ready dropped after a non-search transfer");

  // position never exceeds the table depth, padding is zero
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[POS_W-1:0] <= POS_W'(TABLE_DEPTH))
                        && (m_axis_tdata_o[OUT_DATA_W-1:POS_W] == '0))
    else $error("position out of range");

  // a matching index points at a stored entry
  a_found_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o[POS_W-1:0] < POS_W'(TABLE_DEPTH)))
    else $error("found result with index past the table");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

endmodule : stbs_checker

bind sorted_table_binary_search_top stbs_checker u_stbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
